FILE: sv/app_acl_first_match_core_macros.svh
// assertion macros for the first-match rule engine
`ifndef APP_ACL_FIRST_MATCH_CORE_MACROS_SVH
`define APP_ACL_FIRST_MATCH_CORE_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define ACL_FM_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define ACL_FM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/acl_fm_pkg.sv
// types, codes and the service upgrade function of the first-match rule engine
package acl_fm_pkg;

  localparam int unsigned RULE_DEPTH    = 64;

  localparam int unsigned SLOT_BITS     = 6;
  localparam int unsigned COUNT_BITS    = 7;
  localparam int unsigned APP_BITS      = 16;
  localparam int unsigned DIR_BITS      = 2;
  localparam int unsigned SVC_BITS      = 4;
  localparam int unsigned PORT_BITS     = 16;
  localparam int unsigned VERDICT_BITS  = 2;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [APP_BITS-1:0]   app_t;
  typedef logic [DIR_BITS-1:0]   dir_t;
  typedef logic [SVC_BITS-1:0]   svc_t;
  typedef logic [PORT_BITS-1:0]  port_t;

  localparam logic FUNC_CHECK = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam dir_t  DIR_ANY  = 2'd3;
  localparam port_t PORT_ANY = 16'd0;

  localparam svc_t SVC_ANY    = 4'd0;
  localparam svc_t SVC_TCP    = 4'd1;
  localparam svc_t SVC_FTP    = 4'd3;
  localparam svc_t SVC_TELNET = 4'd4;
  localparam svc_t SVC_POP3   = 4'd5;
  localparam svc_t SVC_SMTP   = 4'd6;
  localparam svc_t SVC_NNTP   = 4'd7;
  localparam svc_t SVC_HTTP   = 4'd8;

  localparam port_t PORT_FTP    = 16'd21;
  localparam port_t PORT_TELNET = 16'd23;
  localparam port_t PORT_POP3   = 16'd110;
  localparam port_t PORT_SMTP   = 16'd25;
  localparam port_t PORT_NNTP   = 16'd119;
  localparam port_t PORT_HTTP   = 16'd80;

  typedef enum logic [VERDICT_BITS-1:0] {
    VERDICT_PASS    = 2'd0,
    VERDICT_DENY    = 2'd1,
    VERDICT_ASK     = 2'd2,
    VERDICT_UNKNOWN = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    MODE_PASS_ALL = 2'd0,
    MODE_DENY_ALL = 2'd1,
    MODE_FILTER   = 2'd2,
    MODE_UNKNOWN  = 2'd3
  } work_mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WORK_MODE    = 2'd0,
    CFG_RULE_COUNT   = 2'd1,
    CFG_FIREWALL_APP = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic  func;
    slot_t rule_index;
    app_t  app_id;
    dir_t  direction;
    svc_t  service;
    port_t remote_port;
    logic  rule_action;
  } in_item_t;

  typedef struct packed {
    logic [VERDICT_BITS-1:0] verdict;
    count_t                  rule_hit;
    svc_t                    service_used;
  } out_item_t;

  typedef struct packed {
    app_t  app;
    dir_t  dir;
    svc_t  svc;
    port_t port;
    logic  deny;
  } rule_t;

  // query travelling along the rule cells
  typedef struct packed {
    logic   valid;
    app_t   app;
    dir_t   dir;
    svc_t   svc;
    port_t  port;
    logic   seen;
    logic   decided;
    logic   deny;
    count_t last;
  } token_t;

  function automatic svc_t upgrade_service(svc_t svc, port_t port);
    svc_t res;
    res = svc;
    if (svc == SVC_TCP) begin
      unique case (port)
        PORT_FTP:    res = SVC_FTP;
        PORT_TELNET: res = SVC_TELNET;
        PORT_POP3:   res = SVC_POP3;
        PORT_SMTP:   res = SVC_SMTP;
        PORT_NNTP:   res = SVC_NNTP;
        PORT_HTTP:   res = SVC_HTTP;
        default:     res = svc;
      endcase
    end
    return res;
  endfunction

endpackage

FILE: sv/acl_fm_cell.sv
// one rule cell: holds one rule and updates the passing query
module acl_fm_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  acl_fm_pkg::slot_t   wr_slot_i,
  input  acl_fm_pkg::rule_t   wr_rule_i,
  input  acl_fm_pkg::count_t  rule_count_i,
  input  acl_fm_pkg::token_t  tok_i,
  output acl_fm_pkg::token_t  tok_o
);

  localparam bit IN_REACH = (CELL_IDX < (1 << acl_fm_pkg::COUNT_BITS));
  localparam bit WRITABLE = (CELL_IDX < (1 << acl_fm_pkg::SLOT_BITS));
  localparam acl_fm_pkg::count_t CELL_POS  = acl_fm_pkg::count_t'(CELL_IDX);
  localparam acl_fm_pkg::slot_t  CELL_SLOT = acl_fm_pkg::slot_t'(CELL_IDX);

  acl_fm_pkg::rule_t  rule_q;
  acl_fm_pkg::token_t tok_q, tok_d;
  logic active;
  logic dir_ok, svc_ok, port_ok;

  assign active  = IN_REACH && (CELL_POS < rule_count_i);
  assign dir_ok  = (rule_q.dir == acl_fm_pkg::DIR_ANY) || (rule_q.dir == tok_i.dir);
  assign svc_ok  = (rule_q.svc == acl_fm_pkg::SVC_ANY) || (rule_q.svc == tok_i.svc);
  assign port_ok = (rule_q.port == acl_fm_pkg::PORT_ANY) || (rule_q.port == tok_i.port);

  always_comb begin
    tok_d = tok_i;
    if (active && !tok_i.decided && (rule_q.app == tok_i.app)) begin
      tok_d.seen = 1'b1;
      tok_d.last = CELL_POS;
      tok_d.deny = rule_q.deny;
      if (dir_ok && svc_ok && port_ok) begin
        tok_d.decided = 1'b1;
      end
    end
  end

  // rule storage, no reset
  always_ff @(posedge clk_i) begin
    if (WRITABLE && wr_en_i && (wr_slot_i == CELL_SLOT)) begin
      rule_q <= wr_rule_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: sv/app_acl_first_match_core.sv
// top level of the first-match rule engine: control, configuration and the rule cell chain
// a rule write, or a check decided by the firewall id or the work mode: result registered
//   at the transfer edge when the output is free, else held until it is; the next item is taken once it is loaded
// a check by rules: the query passes one rule cell per cycle along the RULE_DEPTH cells; no new
//   item is taken until its result is loaded into the output register
// reset clears control state and configuration; rule storage in the cells is not cleared
`include "app_acl_first_match_core_macros.svh"

module app_acl_first_match_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  acl_fm_pkg::in_item_t                  in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output acl_fm_pkg::out_item_t                 out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [acl_fm_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [acl_fm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i
);

  localparam acl_fm_pkg::count_t HIT_NONE = acl_fm_pkg::count_t'(acl_fm_pkg::RULE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  state_e                  state_q;
  acl_fm_pkg::out_item_t   res_q, out_q;
  logic                    out_valid_q;

  acl_fm_pkg::work_mode_e  work_mode_q;
  acl_fm_pkg::count_t      rule_count_q;
  acl_fm_pkg::app_t        fw_app_q;

  acl_fm_pkg::token_t      chain_tok [acl_fm_pkg::RULE_DEPTH+1];
  logic [acl_fm_pkg::RULE_DEPTH:0] chain_valid;

  logic                    in_accept;
  logic                    out_free;
  logic                    out_load;
  logic                    is_write;
  logic                    bypass;
  logic                    launch;
  acl_fm_pkg::svc_t        used;
  acl_fm_pkg::verdict_e    bypass_verdict;
  acl_fm_pkg::out_item_t   imm_res, scan_res, out_next;
  acl_fm_pkg::rule_t       wr_rule;
  acl_fm_pkg::token_t      head_tok;
  acl_fm_pkg::token_t      tail;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_mode_q  <= acl_fm_pkg::MODE_PASS_ALL;
      rule_count_q <= '0;
      fw_app_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        acl_fm_pkg::CFG_WORK_MODE:
          work_mode_q <= acl_fm_pkg::work_mode_e'(cfg_wdata_i[1:0]);
        acl_fm_pkg::CFG_RULE_COUNT:
          rule_count_q <= cfg_wdata_i[acl_fm_pkg::COUNT_BITS-1:0];
        acl_fm_pkg::CFG_FIREWALL_APP:
          fw_app_q <= cfg_wdata_i[acl_fm_pkg::APP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // item decode
  always_comb begin
    is_write = (in_data_i.func == acl_fm_pkg::FUNC_WRITE);
    used     = acl_fm_pkg::upgrade_service(in_data_i.service, in_data_i.remote_port);
    bypass   = 1'b1;
    bypass_verdict = acl_fm_pkg::VERDICT_PASS;
    priority if (in_data_i.app_id == fw_app_q) begin
      bypass_verdict = acl_fm_pkg::VERDICT_PASS;
    end else begin
      unique case (work_mode_q)
        acl_fm_pkg::MODE_PASS_ALL: bypass_verdict = acl_fm_pkg::VERDICT_PASS;
        acl_fm_pkg::MODE_DENY_ALL: bypass_verdict = acl_fm_pkg::VERDICT_DENY;
        acl_fm_pkg::MODE_UNKNOWN:  bypass_verdict = acl_fm_pkg::VERDICT_UNKNOWN;
        acl_fm_pkg::MODE_FILTER:   bypass = 1'b0;
        default:                   bypass = 1'b0;
      endcase
    end
    launch = in_accept && !is_write && !bypass;

    if (is_write) begin
      imm_res.verdict      = acl_fm_pkg::VERDICT_PASS;
      imm_res.rule_hit     = HIT_NONE;
      imm_res.service_used = acl_fm_pkg::SVC_ANY;
    end else begin
      imm_res.verdict      = bypass_verdict;
      imm_res.rule_hit     = HIT_NONE;
      imm_res.service_used = used;
    end

    wr_rule.app  = in_data_i.app_id;
    wr_rule.dir  = in_data_i.direction;
    wr_rule.svc  = in_data_i.service;
    wr_rule.port = in_data_i.remote_port;
    wr_rule.deny = in_data_i.rule_action;

    head_tok.valid   = launch;
    head_tok.app     = in_data_i.app_id;
    head_tok.dir     = in_data_i.direction;
    head_tok.svc     = used;
    head_tok.port    = in_data_i.remote_port;
    head_tok.seen    = 1'b0;
    head_tok.decided = 1'b0;
    head_tok.deny    = 1'b0;
    head_tok.last    = '0;
  end

  assign chain_tok[0] = head_tok;

  // rule cell chain
  for (genvar k = 0; k < acl_fm_pkg::RULE_DEPTH; k++) begin : g_cell
    acl_fm_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .wr_en_i      (in_accept && is_write),
      .wr_slot_i    (in_data_i.rule_index),
      .wr_rule_i    (wr_rule),
      .rule_count_i (rule_count_q),
      .tok_i        (chain_tok[k]),
      .tok_o        (chain_tok[k+1])
    );
  end

  for (genvar k = 0; k <= acl_fm_pkg::RULE_DEPTH; k++) begin : g_valid
    assign chain_valid[k] = chain_tok[k].valid;
  end

  assign tail = chain_tok[acl_fm_pkg::RULE_DEPTH];

  always_comb begin
    scan_res.service_used = tail.svc;
    if (tail.seen) begin
      scan_res.verdict  = tail.deny ? acl_fm_pkg::VERDICT_DENY : acl_fm_pkg::VERDICT_PASS;
      scan_res.rule_hit = tail.last;
    end else begin
      scan_res.verdict  = acl_fm_pkg::VERDICT_ASK;
      scan_res.rule_hit = HIT_NONE;
    end
  end

  // output register load
  always_comb begin
    out_load = 1'b0;
    out_next = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && !launch && out_free) begin
          out_load = 1'b1;
          out_next = imm_res;
        end
      end
      ST_SCAN: begin
        if (tail.valid && out_free) begin
          out_load = 1'b1;
          out_next = scan_res;
        end
      end
      ST_HOLD: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // control and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      res_q       <= '0;
    end else begin
      if (out_load) begin
        out_q       <= out_next;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (launch) begin
              state_q <= ST_SCAN;
            end else if (!out_free) begin
              res_q   <= imm_res;
              state_q <= ST_HOLD;
            end
          end
        end
        ST_SCAN: begin
          if (tail.valid) begin
            if (out_free) begin
              state_q <= ST_IDLE;
            end else begin
              res_q   <= scan_res;
              state_q <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `ACL_FM_ASSERT(a_single_query, 1'b1, $countones(chain_valid) <= 1, "two queries in the chain")
  `ACL_FM_ASSERT(a_tail_in_scan, chain_valid[acl_fm_pkg::RULE_DEPTH], state_q == ST_SCAN, "query left the chain outside scan")
  `ACL_FM_ASSERT_NEXT(a_launch_scans, launch, state_q == ST_SCAN, "launched query not tracked")
  `ACL_FM_ASSERT(a_ask_no_hit, out_valid_o && out_data_o.verdict == acl_fm_pkg::VERDICT_ASK, out_data_o.rule_hit == HIT_NONE, "ask verdict with a rule hit")

endmodule

FILE: sim/app_acl_first_match_core_tb.sv
// self-checking testbench of the first-match rule engine: directed table, then random traffic
module app_acl_first_match_core_tb;

  localparam int RULES     = int'(acl_fm_pkg::RULE_DEPTH);
  localparam int ITEMS     = 1700;
  localparam int LIMIT     = 1_000_000;
  localparam int LONG_HOLD = 400;
  localparam int TAIL      = RULES + 8;
  localparam acl_fm_pkg::count_t NO_HIT = acl_fm_pkg::count_t'(RULES);

  localparam acl_fm_pkg::dir_t DIR_NONE = 2'd0;
  localparam acl_fm_pkg::dir_t DIR_IN   = 2'd1;
  localparam acl_fm_pkg::dir_t DIR_OUT  = 2'd2;
  localparam acl_fm_pkg::svc_t SVC_UDP  = 4'd2;

  typedef logic [acl_fm_pkg::CFG_DATA_BITS-1:0] cfg_word_t;

  typedef struct packed {
    logic                   setup;
    acl_fm_pkg::work_mode_e mode;
    acl_fm_pkg::count_t     count;
    acl_fm_pkg::app_t       fw;
    acl_fm_pkg::in_item_t   item;
    logic                   typed;
    acl_fm_pkg::out_item_t  want;
  } plan_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  acl_fm_pkg::in_item_t  in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  acl_fm_pkg::out_item_t out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [acl_fm_pkg::CFG_IDX_BITS-1:0] cfg_idx_i = acl_fm_pkg::CFG_WORK_MODE;
  cfg_word_t             cfg_wdata_i = '0;

  // predictor state
  acl_fm_pkg::rule_t      acl_rules [RULES];
  acl_fm_pkg::work_mode_e acl_mode  = acl_fm_pkg::MODE_PASS_ALL;
  acl_fm_pkg::count_t     acl_count = '0;
  acl_fm_pkg::app_t       own_app   = '0;

  acl_fm_pkg::out_item_t  pending_verdicts [$];
  plan_row_t              plan [$];
  acl_fm_pkg::app_t       app_pool [8];
  acl_fm_pkg::port_t      common_ports [8];
  acl_fm_pkg::out_item_t  result_want;

  int  errors       = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  int  hold_left    = 0;
  int  cycles       = 0;
  bit  in_quiet     = 1'b0;
  bit  out_quiet    = 1'b0;

  app_acl_first_match_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic acl_fm_pkg::svc_t promote_service(input acl_fm_pkg::svc_t svc,
                                                       input acl_fm_pkg::port_t port);
    if (svc != acl_fm_pkg::SVC_TCP) return svc;
    unique case (port)
      acl_fm_pkg::PORT_FTP:    return acl_fm_pkg::SVC_FTP;
      acl_fm_pkg::PORT_TELNET: return acl_fm_pkg::SVC_TELNET;
      acl_fm_pkg::PORT_POP3:   return acl_fm_pkg::SVC_POP3;
      acl_fm_pkg::PORT_SMTP:   return acl_fm_pkg::SVC_SMTP;
      acl_fm_pkg::PORT_NNTP:   return acl_fm_pkg::SVC_NNTP;
      acl_fm_pkg::PORT_HTTP:   return acl_fm_pkg::SVC_HTTP;
      default:                 return svc;
    endcase
  endfunction

  function automatic acl_fm_pkg::out_item_t predict_verdict(input acl_fm_pkg::in_item_t it);
    acl_fm_pkg::out_item_t r;
    int                    span;
    bit                    seen;
    bit                    decided;
    int                    last;
    r.verdict      = acl_fm_pkg::VERDICT_PASS;
    r.rule_hit     = NO_HIT;
    r.service_used = acl_fm_pkg::SVC_ANY;
    seen    = 1'b0;
    decided = 1'b0;
    last    = 0;
    if (it.func == acl_fm_pkg::FUNC_WRITE) begin
      acl_rules[it.rule_index].app  = it.app_id;
      acl_rules[it.rule_index].dir  = it.direction;
      acl_rules[it.rule_index].svc  = it.service;
      acl_rules[it.rule_index].port = it.remote_port;
      acl_rules[it.rule_index].deny = it.rule_action;
      return r;
    end
    r.service_used = promote_service(it.service, it.remote_port);
    if (it.app_id == own_app) return r;
    case (acl_mode)
      acl_fm_pkg::MODE_PASS_ALL: r.verdict = acl_fm_pkg::VERDICT_PASS;
      acl_fm_pkg::MODE_DENY_ALL: r.verdict = acl_fm_pkg::VERDICT_DENY;
      acl_fm_pkg::MODE_UNKNOWN:  r.verdict = acl_fm_pkg::VERDICT_UNKNOWN;
      default: begin
        span = (int'(acl_count) > RULES) ? RULES : int'(acl_count);
        for (int i = 0; i < span && !decided; i++) begin
          if (acl_rules[i].app != it.app_id) continue;
          seen = 1'b1;
          last = i;
          if (acl_rules[i].dir != acl_fm_pkg::DIR_ANY &&
              acl_rules[i].dir != it.direction) continue;
          if (acl_rules[i].svc != acl_fm_pkg::SVC_ANY &&
              acl_rules[i].svc != r.service_used) continue;
          if (acl_rules[i].port != acl_fm_pkg::PORT_ANY &&
              acl_rules[i].port != it.remote_port) continue;
          decided = 1'b1;
        end
        if (seen) begin
          r.rule_hit = acl_fm_pkg::count_t'(last);
          r.verdict  = acl_rules[last].deny ? acl_fm_pkg::VERDICT_DENY
                                            : acl_fm_pkg::VERDICT_PASS;
        end else begin
          r.verdict = acl_fm_pkg::VERDICT_ASK;
        end
      end
    endcase
    return r;
  endfunction

  function automatic acl_fm_pkg::in_item_t write_item(input acl_fm_pkg::slot_t s,
                                                      input acl_fm_pkg::app_t a,
                                                      input acl_fm_pkg::dir_t d,
                                                      input acl_fm_pkg::svc_t v,
                                                      input acl_fm_pkg::port_t p,
                                                      input logic act);
    acl_fm_pkg::in_item_t it;
    it.func        = acl_fm_pkg::FUNC_WRITE;
    it.rule_index  = s;
    it.app_id      = a;
    it.direction   = d;
    it.service     = v;
    it.remote_port = p;
    it.rule_action = act;
    return it;
  endfunction

  // index and action carry noise on a check
  function automatic acl_fm_pkg::in_item_t check_item(input acl_fm_pkg::app_t a,
                                                      input acl_fm_pkg::dir_t d,
                                                      input acl_fm_pkg::svc_t v,
                                                      input acl_fm_pkg::port_t p);
    acl_fm_pkg::in_item_t it;
    it.func        = acl_fm_pkg::FUNC_CHECK;
    it.rule_index  = acl_fm_pkg::slot_t'($urandom_range(0, RULES - 1));
    it.app_id      = a;
    it.direction   = d;
    it.service     = v;
    it.remote_port = p;
    it.rule_action = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic acl_fm_pkg::app_t pick_app();
    if ($urandom_range(0, 19) < 17) return app_pool[$urandom_range(0, 7)];
    return acl_fm_pkg::app_t'($urandom);
  endfunction

  function automatic acl_fm_pkg::svc_t pick_service();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 4) return acl_fm_pkg::SVC_TCP;
    if (k < 9) return acl_fm_pkg::svc_t'($urandom_range(0, 8));
    return acl_fm_pkg::svc_t'($urandom_range(0, 15));
  endfunction

  function automatic acl_fm_pkg::port_t pick_port();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 6) return common_ports[$urandom_range(0, 7)];
    if (k < 7) return acl_fm_pkg::PORT_ANY;
    return acl_fm_pkg::port_t'($urandom);
  endfunction

  function automatic acl_fm_pkg::in_item_t random_rule(input acl_fm_pkg::slot_t s);
    return write_item(s, pick_app(), acl_fm_pkg::dir_t'($urandom_range(0, 3)),
                      ($urandom_range(0, 4) < 2) ? acl_fm_pkg::SVC_ANY : pick_service(),
                      ($urandom_range(0, 1) == 0) ? acl_fm_pkg::PORT_ANY : pick_port(),
                      1'($urandom_range(0, 1)));
  endfunction

  function automatic acl_fm_pkg::in_item_t random_item();
    if ($urandom_range(0, 9) < 3)
      return random_rule(acl_fm_pkg::slot_t'($urandom_range(0, RULES - 1)));
    return check_item(pick_app(), acl_fm_pkg::dir_t'($urandom_range(0, 3)), pick_service(),
                      pick_port());
  endfunction

  task automatic plan_setup(input acl_fm_pkg::work_mode_e m, input acl_fm_pkg::count_t c,
                            input acl_fm_pkg::app_t f);
    plan_row_t row;
    row       = '0;
    row.setup = 1'b1;
    row.mode  = m;
    row.count = c;
    row.fw    = f;
    plan.push_back(row);
  endtask

  task automatic plan_pred(input acl_fm_pkg::in_item_t it);
    plan_row_t row;
    row      = '0;
    row.item = it;
    plan.push_back(row);
  endtask

  task automatic plan_typed(input acl_fm_pkg::in_item_t it, input acl_fm_pkg::verdict_e v,
                            input acl_fm_pkg::count_t hit, input acl_fm_pkg::svc_t used);
    plan_row_t row;
    row                   = '0;
    row.item              = it;
    row.typed             = 1'b1;
    row.want.verdict      = v;
    row.want.rule_hit     = hit;
    row.want.service_used = used;
    plan.push_back(row);
  endtask

  task automatic send_item(input acl_fm_pkg::in_item_t it, input logic typed,
                           input acl_fm_pkg::out_item_t want);
    int                    gap;
    acl_fm_pkg::out_item_t model_out;
    gap = in_quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    model_out = predict_verdict(it);
    pending_verdicts.push_back(typed ? want : model_out);
    items_sent++;
  endtask

  task automatic finish_phase();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts.size() != 0);
  endtask

  task automatic load_config(input acl_fm_pkg::work_mode_e m, input acl_fm_pkg::count_t c,
                             input acl_fm_pkg::app_t f);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= acl_fm_pkg::CFG_WORK_MODE;
    cfg_wdata_i <= cfg_word_t'(m);
    @(posedge clk_i);
    cfg_idx_i   <= acl_fm_pkg::CFG_RULE_COUNT;
    cfg_wdata_i <= cfg_word_t'(c);
    @(posedge clk_i);
    cfg_idx_i   <= acl_fm_pkg::CFG_FIREWALL_APP;
    cfg_wdata_i <= cfg_word_t'(f);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    acl_mode  = m;
    acl_count = c;
    own_app   = f;
  endtask

  // result side: per-transfer stall draw, plus long hold-offs to back the block up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected result verdict %0d rule_hit %0d service_used %0d",
                   $time, out_data_o.verdict, out_data_o.rule_hit, out_data_o.service_used);
          errors++;
        end else begin
          result_want = pending_verdicts.pop_front();
          if (out_data_o.verdict !== result_want.verdict) begin
            $display("%0t: verdict expected %0d actual %0d", $time,
                     result_want.verdict, out_data_o.verdict);
            errors++;
          end
          if (out_data_o.rule_hit !== result_want.rule_hit) begin
            $display("%0t: rule_hit expected %0d actual %0d", $time,
                     result_want.rule_hit, out_data_o.rule_hit);
            errors++;
          end
          if (out_data_o.service_used !== result_want.service_used) begin
            $display("%0t: service_used expected %0d actual %0d", $time,
                     result_want.service_used, out_data_o.service_used);
            errors++;
          end
        end
        results_seen++;
        if (results_seen == 50 || results_seen == 1000) hold_left = LONG_HOLD;
        else hold_left = out_quiet ? 0 : $urandom_range(0, 16);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left > 0);
    end
  end

  initial begin
    int                     burst;
    int                     phase;
    acl_fm_pkg::work_mode_e mode;
    acl_fm_pkg::count_t     count;
    acl_fm_pkg::app_t       fw;

    app_pool[0] = 16'h0000;
    app_pool[1] = 16'hFFFF;
    app_pool[2] = 16'h1234;
    for (int i = 3; i < 8; i++) app_pool[i] = acl_fm_pkg::app_t'($urandom);
    common_ports[0] = acl_fm_pkg::PORT_FTP;
    common_ports[1] = acl_fm_pkg::PORT_TELNET;
    common_ports[2] = acl_fm_pkg::PORT_SMTP;
    common_ports[3] = acl_fm_pkg::PORT_HTTP;
    common_ports[4] = acl_fm_pkg::PORT_POP3;
    common_ports[5] = acl_fm_pkg::PORT_NNTP;
    common_ports[6] = 16'd443;
    common_ports[7] = 16'd8080;

    // pass-all after reset, then a small rule set checked in deny-all, unknown and filter modes
    plan_typed(check_item(16'hFFFF, acl_fm_pkg::DIR_ANY, acl_fm_pkg::SVC_TCP,
                          acl_fm_pkg::PORT_HTTP),
               acl_fm_pkg::VERDICT_PASS, NO_HIT, acl_fm_pkg::SVC_HTTP);
    plan_typed(write_item(6'd0, 16'h1234, DIR_IN, acl_fm_pkg::SVC_TCP, acl_fm_pkg::PORT_ANY,
                          1'b1),
               acl_fm_pkg::VERDICT_PASS, NO_HIT, acl_fm_pkg::SVC_ANY);
    plan_typed(write_item(6'd1, 16'h1234, acl_fm_pkg::DIR_ANY, acl_fm_pkg::SVC_ANY,
                          acl_fm_pkg::PORT_ANY, 1'b0),
               acl_fm_pkg::VERDICT_PASS, NO_HIT, acl_fm_pkg::SVC_ANY);
    plan_typed(write_item(6'd2, 16'hFFFF, DIR_OUT, acl_fm_pkg::SVC_HTTP, 16'd8080, 1'b1),
               acl_fm_pkg::VERDICT_PASS, NO_HIT, acl_fm_pkg::SVC_ANY);
    plan_typed(write_item(6'd3, 16'hABCD, DIR_IN, 4'hF, 16'hFFFF, 1'b0),
               acl_fm_pkg::VERDICT_PASS, NO_HIT, acl_fm_pkg::SVC_ANY);
    plan_typed(write_item(6'd63, 16'h0000, DIR_NONE, 4'hF, 16'hFFFF, 1'b1),
               acl_fm_pkg::VERDICT_PASS, NO_HIT, acl_fm_pkg::SVC_ANY);
    plan_setup(acl_fm_pkg::MODE_DENY_ALL, 7'd4, 16'hABCD);
    plan_typed(check_item(16'h1234, DIR_IN, SVC_UDP, acl_fm_pkg::PORT_SMTP),
               acl_fm_pkg::VERDICT_DENY, NO_HIT, SVC_UDP);
    plan_typed(check_item(16'hABCD, DIR_OUT, acl_fm_pkg::SVC_TCP, acl_fm_pkg::PORT_FTP),
               acl_fm_pkg::VERDICT_PASS, NO_HIT, acl_fm_pkg::SVC_FTP);
    plan_setup(acl_fm_pkg::MODE_UNKNOWN, 7'd4, 16'h0000);
    plan_typed(check_item(16'h1234, DIR_NONE, acl_fm_pkg::SVC_ANY, acl_fm_pkg::PORT_ANY),
               acl_fm_pkg::VERDICT_UNKNOWN, NO_HIT, acl_fm_pkg::SVC_ANY);
    plan_typed(check_item(16'h0000, DIR_IN, acl_fm_pkg::SVC_TCP, acl_fm_pkg::PORT_TELNET),
               acl_fm_pkg::VERDICT_PASS, NO_HIT, acl_fm_pkg::SVC_TELNET);
    plan_setup(acl_fm_pkg::MODE_FILTER, 7'd4, 16'h0001);
    plan_pred(check_item(16'h1234, DIR_IN, acl_fm_pkg::SVC_TCP, acl_fm_pkg::PORT_POP3));
    plan_pred(check_item(16'h1234, DIR_IN, acl_fm_pkg::SVC_TCP, 16'd1000));
    plan_pred(check_item(16'h1234, DIR_OUT, SVC_UDP, 16'hFFFF));
    plan_pred(check_item(16'hFFFF, DIR_OUT, acl_fm_pkg::SVC_TCP, acl_fm_pkg::PORT_HTTP));
    plan_pred(check_item(16'hFFFF, DIR_OUT, SVC_UDP, 16'd8080));
    plan_typed(check_item(16'h5555, DIR_IN, acl_fm_pkg::SVC_TCP, acl_fm_pkg::PORT_NNTP),
               acl_fm_pkg::VERDICT_ASK, NO_HIT, acl_fm_pkg::SVC_NNTP);
    plan_pred(check_item(16'hABCD, DIR_IN, 4'hF, 16'hFFFF));
    plan_pred(check_item(16'h1234, DIR_NONE, acl_fm_pkg::SVC_TCP, acl_fm_pkg::PORT_NNTP));
    plan_typed(check_item(16'h0001, DIR_OUT, acl_fm_pkg::SVC_TCP, acl_fm_pkg::PORT_SMTP),
               acl_fm_pkg::VERDICT_PASS, NO_HIT, acl_fm_pkg::SVC_SMTP);
    plan_setup(acl_fm_pkg::MODE_FILTER, 7'd0, 16'h0001);
    plan_typed(check_item(16'h1234, DIR_IN, acl_fm_pkg::SVC_TCP, acl_fm_pkg::PORT_ANY),
               acl_fm_pkg::VERDICT_ASK, NO_HIT, acl_fm_pkg::SVC_TCP);
    plan_setup(acl_fm_pkg::MODE_FILTER, 7'd1, 16'h0001);
    plan_pred(check_item(16'h1234, DIR_OUT, acl_fm_pkg::SVC_TCP, 16'd443));
    plan_pred(check_item(16'h1234, DIR_IN, acl_fm_pkg::SVC_TCP, acl_fm_pkg::PORT_HTTP));
    plan_typed(check_item(16'h0000, acl_fm_pkg::DIR_ANY, acl_fm_pkg::SVC_ANY,
                          acl_fm_pkg::PORT_ANY),
               acl_fm_pkg::VERDICT_ASK, NO_HIT, acl_fm_pkg::SVC_ANY);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].setup) begin
        finish_phase();
        load_config(plan[k].mode, plan[k].count, plan[k].fw);
      end else begin
        send_item(plan[k].item, plan[k].typed, plan[k].want);
      end
    end

    // fill the whole table so that any rule count scans written slots only
    for (int s = 0; s < RULES; s++) send_item(random_rule(acl_fm_pkg::slot_t'(s)), 1'b0, '0);

    phase = 0;
    while (items_sent < ITEMS) begin
      finish_phase();
      if (phase == 0) begin
        mode  = acl_fm_pkg::MODE_FILTER;
        count = 7'd127;
        fw    = 16'hFFFF;
      end else if (phase == 1) begin
        mode  = acl_fm_pkg::MODE_FILTER;
        count = acl_fm_pkg::count_t'(RULES);
        fw    = 16'h0000;
      end else begin
        case ($urandom_range(0, 9))
          6:       mode = acl_fm_pkg::MODE_PASS_ALL;
          7:       mode = acl_fm_pkg::MODE_DENY_ALL;
          8:       mode = acl_fm_pkg::MODE_UNKNOWN;
          default: mode = acl_fm_pkg::MODE_FILTER;
        endcase
        case ($urandom_range(0, 5))
          0:       count = '0;
          1:       count = acl_fm_pkg::count_t'(RULES);
          2:       count = 7'd127;
          3:       count = acl_fm_pkg::count_t'($urandom_range(1, 16));
          4:       count = acl_fm_pkg::count_t'($urandom_range(17, RULES));
          default: count = acl_fm_pkg::count_t'($urandom_range(RULES + 1, 127));
        endcase
        case ($urandom_range(0, 3))
          0:       fw = app_pool[$urandom_range(0, 7)];
          1:       fw = acl_fm_pkg::app_t'($urandom);
          2:       fw = 16'h0000;
          default: fw = 16'hFFFF;
        endcase
      end
      load_config(mode, count, fw);
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(20, 120);
      repeat (burst) send_item(random_item(), 1'b0, '0);
      phase++;
    end

    finish_phase();
    repeat (TAIL) @(posedge clk_i);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: app_acl_first_match_core.f
+incdir+sv
sv/acl_fm_pkg.sv
sv/acl_fm_cell.sv
sv/app_acl_first_match_core.sv
sim/app_acl_first_match_core_tb.sv
